// ----- src/bal_pkg.sv -----
// Shared types and constants for the bounded array list.
`timescale 1ns / 1ps
package bal_pkg;

  // Field widths of the request and response beats.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Largest supported capacity and the position width that covers it.
  localparam int unsigned CAPACITY_MAX = 1024;
  localparam int unsigned POS_W        = $clog2(CAPACITY_MAX + 1);
  localparam int unsigned CAPACITY_DEF = 16;

  // Number of entries that the request index can address.
  localparam int unsigned IDX_SPAN = 1 << IDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_GET    = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] load_pos;
    logic             shift_up;
    logic             shift_down;
    logic [POS_W-1:0] pivot;
  } cell_ctrl_t;

endpackage

// ----- src/bal_if.sv -----
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps
interface bal_req_if import bal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  index;
  logic [WORD_W-1:0] value_in;

  modport source (output valid, operation, index, value_in, input ready);
  modport sink   (input valid, operation, index, value_in, output ready);
endinterface

interface bal_rsp_if import bal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] value_out;
  logic [COUNT_W-1:0]       count_now;

  modport source (output valid, status, value_out, count_now, input ready);
  modport sink   (input valid, status, value_out, count_now, output ready);
endinterface

// ----- src/bal_cell.sv -----
// One storage cell of the list: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps
module bal_cell import bal_pkg::*; #(
  parameter int unsigned POS = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] word_o
);

  localparam logic [POS_W-1:0] MyPos = POS_W'(POS);

  logic [WORD_W-1:0] word_d, word_q;

  // A direct write wins; otherwise the cell follows the shift direction.
  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && (ctrl_i.load_pos == MyPos)) begin
      word_d = value_i;
    end else if (ctrl_i.shift_up && (MyPos > ctrl_i.pivot)) begin
      word_d = left_i;
    end else if (ctrl_i.shift_down && (MyPos >= ctrl_i.pivot)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- src/bounded_array_list.sv -----
// Top level of the bounded array list: request decode, count and the cell row.
//
// Usage:
//   Requests arrive on req_i (operation, index, value_in) and each produces
//   exactly one beat on rsp_o (status, value_out, count_now). A beat moves
//   when valid and ready are both high.
//   Every operation, including insert and remove, is applied to the row at once:
//   the cells at and beyond the index shift toward their neighbor in the same cycle, so
//   the response beat appears the cycle after the request is taken.
//   Throughput is one request per cycle while the receiver keeps up; the
//   single response register sets that figure.
//   When the receiver stalls, the response is held in its register and
//   req_i.ready stays low until that beat is taken, so at most one request
//   is in flight.
//   Reset clears the word count and the response valid flag; the stored
//   words are not cleared and are only read below the count.
`timescale 1ns / 1ps
module bounded_array_list import bal_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bal_req_if.sink   req_i,
  bal_rsp_if.source rsp_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned RD_N = (CAPACITY < IDX_SPAN) ? CAPACITY : IDX_SPAN;
  localparam logic [POS_W-1:0] CapPos = POS_W'(CAPACITY);

  logic [CW-1:0]      count_d, count_q;
  logic               rsp_valid_q;
  logic [STAT_W-1:0]  status_d, status_q;
  logic [WORD_W-1:0]  value_d, value_q;
  logic [COUNT_W-1:0] count_now_q;

  logic [WORD_W-1:0] words [CAPACITY];
  logic [WORD_W-1:0] rd_tab [IDX_SPAN];
  logic [WORD_W-1:0] rd_word;
  cell_ctrl_t        ctrl;

  logic             accept;
  logic [POS_W-1:0] idx_pos, cnt_pos;
  logic             in_range, full, empty;

  // One request in flight: take a new one once the response slot frees up.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign idx_pos  = POS_W'(req_i.index);
  assign cnt_pos  = POS_W'(count_q);
  assign in_range = (idx_pos < cnt_pos) && (idx_pos < CapPos);
  assign full     = (cnt_pos >= CapPos);
  assign empty    = (count_q == '0);

  // Read port over the addressable part of the row.
  for (genvar j = 0; j < IDX_SPAN; j++) begin : g_rd
    if (j < RD_N) begin : g_live
      assign rd_tab[j] = words[j];
    end else begin : g_dead
      assign rd_tab[j] = '0;
    end
  end
  assign rd_word = rd_tab[req_i.index];

  // Decode the request into a row command, status and next count.
  always_comb begin
    ctrl            = '0;
    ctrl.load_pos   = idx_pos;
    ctrl.pivot      = idx_pos;
    status_d        = ST_OK;
    value_d         = '0;
    count_d         = count_q;
    unique case (op_e'(req_i.operation))
      OP_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.load     = 1'b1;
          ctrl.load_pos = cnt_pos;
          count_d       = count_q + CW'(1);
        end
      end
      OP_SET: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          value_d   = rd_word;
          ctrl.load = 1'b1;
        end
      end
      OP_INSERT: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.load     = 1'b1;
          ctrl.shift_up = 1'b1;
          count_d       = count_q + CW'(1);
        end
      end
      OP_GET: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          value_d = rd_word;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          value_d         = rd_word;
          ctrl.shift_down = 1'b1;
          count_d         = count_q - CW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    if (!accept) begin
      ctrl.load       = 1'b0;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
    end
  end

  // Row of cells; each end sees zero beyond the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[i+1];
    end
    bal_cell #(
      .POS(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .value_i(req_i.value_in),
      .left_i (left_w),
      .right_i(right_w),
      .word_o (words[i])
    );
  end

  // Count and response valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      value_q     <= value_d;
      count_now_q <= COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.value_out = value_q;
  assign rsp_o.count_now = count_now_q;

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    POS_W'(count_q) <= CapPos)
    else $error("word count above capacity");

  // A taken request always yields a response beat in the next cycle.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request produced no response");

  // A full response means the list still holds its capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q == ST_FULL)) |-> (POS_W'(count_q) == CapPos))
    else $error("full status with count below capacity");

  // A refused request returns no word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q != ST_OK)) |-> (value_q == '0))
    else $error("error response carries a word");

endmodule
